FILE: rtl/core/dls_pkg.sv
// Shared types, sizes and table helpers for the dense layer engine.
// Depends on nothing; design files use scoped names, the testbench imports it.
package dls_pkg;

	// Array geometry.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int W_DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int V_DEPTH  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int W_AW     = $clog2(W_DEPTH);
	localparam int V_AW     = $clog2(V_DEPTH);

	// Field and datapath widths.
	localparam int SIZE_W = 7;
	localparam int IDX_W  = 12;
	localparam int VAL_W  = 16;
	localparam int OIDX_W = 6;
	localparam int ACT_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = 40;
	localparam int CFG_IW = 2;

	// Clamp bounds of the accumulator, Q8.24: [-8, 8 - 2^-24].
	localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd134217727);
	localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_W'(64'sd134217728);

	// e^(-1/32) in Q0.32, step of the sigmoid table construction.
	localparam logic [63:0] EXP_STEP = 64'd4162825044;

	typedef enum logic [1:0] {
		OP_WEIGHT = 2'd0,
		OP_BIAS   = 2'd1,
		OP_DATA   = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1,
		CFG_DIR  = 2'd2,
		CFG_NONE = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_ISSUE,
		ST_WAIT
	} state_t;

	// Tag that travels with each multiply-accumulate term.
	typedef struct packed {
		logic            valid;
		logic            first;
		logic            last_term;
		logic            last_neuron;
		logic [V_AW-1:0] k;
	} tag_t;

	// One term issued to the datapath.
	typedef struct packed {
		tag_t            tag;
		logic [W_AW-1:0] w_addr;
		logic [V_AW-1:0] t;
	} issue_t;

	// Store write from a load item.
	typedef struct packed {
		logic                    en;
		op_t                     op;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} wr_t;

	typedef struct packed {
		logic empty;
	} status_t;

	// Rounded Q0.32 product.
	function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
		return (a * b + 64'h8000_0000) >> 32;
	endfunction

	// E^(2m+1) in Q0.32, built by repeated rounded multiplication.
	function automatic logic [63:0] exp_power(input int m);
		logic [63:0] p;
		p = EXP_STEP;
		for (int i = 0; i < 127; i++) begin
			if (i < m) begin
				p = mul_q32(mul_q32(p, EXP_STEP), EXP_STEP);
			end
		end
		return p;
	endfunction

endpackage

FILE: rtl/core/dls_if.sv
// Channel interfaces of the dense layer engine: load/run items in, results out.
// Depends on dls_pkg for field widths.
interface dls_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      op;
	logic [dls_pkg::IDX_W-1:0]       index;
	logic signed [dls_pkg::VAL_W-1:0] value;

	modport source(output valid, op, index, value, input ready);
	modport sink(input valid, op, index, value, output ready);
endinterface

interface dls_res_if;
	logic                        valid;
	logic                        ready;
	logic [dls_pkg::OIDX_W-1:0]  out_index;
	logic [dls_pkg::ACT_W-1:0]   activation;
	logic                        last;

	modport source(output valid, out_index, activation, last, input ready);
	modport sink(input valid, out_index, activation, last, output ready);
endinterface

FILE: rtl/core/dls_ctrl.sv
// Controller of the dense layer engine: configuration registers, the run
// sequencer and the weight address generator. Depends on dls_pkg.
module dls_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dls_pkg::CFG_IW-1:0]    cfg_index,
	input  logic [dls_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [1:0]                    cmd_op,
	input  logic [dls_pkg::IDX_W-1:0]     cmd_index,
	input  logic signed [dls_pkg::VAL_W-1:0] cmd_value,
	input  dls_pkg::status_t              status,
	output dls_pkg::wr_t                  wr,
	output dls_pkg::issue_t               issue
);

	dls_pkg::state_t state_q, state_d;

	logic [dls_pkg::SIZE_W-1:0] rows_q, cols_q;
	logic                       dir_up_q;

	logic [dls_pkg::SIZE_W-1:0] n_eff, m_eff, inner, outs;
	logic [dls_pkg::W_AW-1:0]   step, adv;
	logic [dls_pkg::V_AW-1:0]   t_q, k_q;
	logic [dls_pkg::W_AW-1:0]   waddr_q, base_q;
	logic                       last_term, last_neuron, accept, is_run;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= dls_pkg::SIZE_W'(dls_pkg::MAX_ROWS);
			cols_q   <= dls_pkg::SIZE_W'(dls_pkg::MAX_COLS);
			dir_up_q <= 1'b1;
		end else if (cfg_we) begin
			case (dls_pkg::cfg_idx_t'(cfg_index))
				dls_pkg::CFG_ROWS: rows_q   <= cfg_data;
				dls_pkg::CFG_COLS: cols_q   <= cfg_data;
				dls_pkg::CFG_DIR:  dir_up_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective sizes: zero counts as one, anything above the maximum as the maximum.
	always_comb begin
		if (rows_q == '0) begin
			n_eff = dls_pkg::SIZE_W'(1);
		end else if (rows_q > dls_pkg::SIZE_W'(dls_pkg::MAX_ROWS)) begin
			n_eff = dls_pkg::SIZE_W'(dls_pkg::MAX_ROWS);
		end else begin
			n_eff = rows_q;
		end
		if (cols_q == '0) begin
			m_eff = dls_pkg::SIZE_W'(1);
		end else if (cols_q > dls_pkg::SIZE_W'(dls_pkg::MAX_COLS)) begin
			m_eff = dls_pkg::SIZE_W'(dls_pkg::MAX_COLS);
		end else begin
			m_eff = cols_q;
		end
	end

	// Forward walks a row (unit step); transposed walks a column (step of one row).
	assign inner = dir_up_q ? m_eff : n_eff;
	assign outs  = dir_up_q ? n_eff : m_eff;
	assign step  = dir_up_q ? dls_pkg::W_AW'(1) : dls_pkg::W_AW'(m_eff);
	assign adv   = dir_up_q ? dls_pkg::W_AW'(m_eff) : dls_pkg::W_AW'(1);

	assign last_term   = ({1'b0, t_q} == dls_pkg::SIZE_W'(inner - dls_pkg::SIZE_W'(1)));
	assign last_neuron = ({1'b0, k_q} == dls_pkg::SIZE_W'(outs - dls_pkg::SIZE_W'(1)));

	assign cmd_ready = (state_q == dls_pkg::ST_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign is_run    = (dls_pkg::op_t'(cmd_op) == dls_pkg::OP_RUN);

	// Load items go straight to the stores.
	assign wr.en    = accept && !is_run;
	assign wr.op    = dls_pkg::op_t'(cmd_op);
	assign wr.index = cmd_index;
	assign wr.value = cmd_value;

	// Term issued this cycle.
	assign issue.tag.valid       = (state_q == dls_pkg::ST_ISSUE);
	assign issue.tag.first       = (t_q == '0);
	assign issue.tag.last_term   = last_term;
	assign issue.tag.last_neuron = last_neuron;
	assign issue.tag.k           = k_q;
	assign issue.w_addr          = waddr_q;
	assign issue.t               = t_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dls_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state. The last neuron hands back to idle once its terms are issued.
	always_comb begin
		state_d = state_q;
		case (state_q)
			dls_pkg::ST_IDLE: begin
				if (accept && is_run) state_d = dls_pkg::ST_START;
			end
			dls_pkg::ST_START: begin
				if (status.empty) state_d = dls_pkg::ST_ISSUE;
			end
			dls_pkg::ST_ISSUE: begin
				if (last_term) state_d = last_neuron ? dls_pkg::ST_IDLE : dls_pkg::ST_WAIT;
			end
			dls_pkg::ST_WAIT: begin
				if (status.empty) state_d = dls_pkg::ST_ISSUE;
			end
			default: state_d = dls_pkg::ST_IDLE;
		endcase
	end

	// Neuron, term and weight address counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q     <= '0;
			k_q     <= '0;
			waddr_q <= '0;
			base_q  <= '0;
		end else begin
			case (state_q)
				dls_pkg::ST_START: begin
					t_q     <= '0;
					k_q     <= '0;
					waddr_q <= '0;
					base_q  <= '0;
				end
				dls_pkg::ST_ISSUE: begin
					t_q     <= t_q + dls_pkg::V_AW'(1);
					waddr_q <= waddr_q + step;
					if (last_term) base_q <= base_q + adv;
				end
				dls_pkg::ST_WAIT: begin
					if (status.empty) begin
						t_q     <= '0;
						k_q     <= k_q + dls_pkg::V_AW'(1);
						waddr_q <= base_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/dls_datapath.sv
// Datapath of the dense layer engine: weight, bias and data stores, the
// multiply-accumulate pipeline, clamp, sigmoid table and result register. Depends on dls_pkg.
module dls_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dls_pkg::wr_t                     wr,
	input  dls_pkg::issue_t                  issue,
	output dls_pkg::status_t                 status,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [dls_pkg::OIDX_W-1:0]       res_out_index,
	output logic [dls_pkg::ACT_W-1:0]        res_activation,
	output logic                             res_last
);

	logic [dls_pkg::VAL_W-1:0] wmem [dls_pkg::W_DEPTH];
	logic [dls_pkg::VAL_W-1:0] bmem [dls_pkg::V_DEPTH];
	logic [dls_pkg::VAL_W-1:0] dmem [dls_pkg::V_DEPTH];

	logic [dls_pkg::ACT_W-1:0] sig_rom [256];

	dls_pkg::tag_t tag_s1, tag_s2;
	logic [dls_pkg::VAL_W-1:0] w_s1, d_s1, b_s1, b_s2;
	logic signed [dls_pkg::PROD_W-1:0] prod_s2;
	logic signed [dls_pkg::ACC_W-1:0]  acc_q, acc_base, acc_next;
	logic                       done_s3, lastn_s3;
	logic [dls_pkg::V_AW-1:0]   k_s3;
	logic [7:0]                 sig_sel;
	logic                       out_valid_q, out_last_q;
	logic [dls_pkg::OIDX_W-1:0] out_index_q;
	logic [dls_pkg::ACT_W-1:0]  out_act_q;

	// Sigmoid table: upper half from the rounded reciprocal, lower half mirrored.
	for (genvar m = 0; m < 128; m++) begin : g_sig
		localparam logic [63:0] P   = dls_pkg::exp_power(m);
		localparam logic [63:0] DEN = 64'h1_0000_0000 + P;
		localparam logic [63:0] S   = ((64'd1 << 48) + (DEN >> 1)) / DEN;
		localparam logic [15:0] HI  = (S > 64'd65535) ? 16'hFFFF : S[15:0];
		localparam logic [16:0] LO  = 17'h10000 - S[16:0];
		assign sig_rom[128 + m] = HI;
		assign sig_rom[127 - m] = LO[15:0];
	end

	// Store writes; indices beyond a store's depth are dropped.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (wr.op)
				dls_pkg::OP_WEIGHT: begin
					if ({1'b0, wr.index} < 13'(dls_pkg::W_DEPTH))
						wmem[wr.index[dls_pkg::W_AW-1:0]] <= wr.value;
				end
				dls_pkg::OP_BIAS: begin
					if ({1'b0, wr.index} < 13'(dls_pkg::V_DEPTH))
						bmem[wr.index[dls_pkg::V_AW-1:0]] <= wr.value;
				end
				dls_pkg::OP_DATA: begin
					if ({1'b0, wr.index} < 13'(dls_pkg::V_DEPTH))
						dmem[wr.index[dls_pkg::V_AW-1:0]] <= wr.value;
				end
				default: ;
			endcase
		end
	end

	// Stage 1: registered store reads.
	always_ff @(posedge clk) begin
		w_s1 <= wmem[issue.w_addr];
		d_s1 <= dmem[issue.t];
		b_s1 <= bmem[issue.tag.k];
	end

	// Stage 2: product of weight and data.
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_s1) * $signed(d_s1);
		b_s2    <= b_s1;
	end

	// Tags follow the terms through the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= issue.tag;
			tag_s2 <= tag_s1;
		end
	end

	// Stage 3: accumulate; the first term of a neuron starts from the widened bias.
	assign acc_base = tag_s2.first ? $signed({{12{b_s2[15]}}, b_s2, 12'b0}) : acc_q;
	assign acc_next = acc_base + $signed({{(dls_pkg::ACC_W - dls_pkg::PROD_W){prod_s2[31]}},
		prod_s2});

	always_ff @(posedge clk) begin
		if (tag_s2.valid) acc_q <= acc_next;
		k_s3     <= tag_s2.k;
		lastn_s3 <= tag_s2.last_neuron;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= tag_s2.valid && tag_s2.last_term;
		end
	end

	// Clamp to [-8, 8) and pick the table cell of width 1/16.
	always_comb begin
		if (acc_q > dls_pkg::ACC_MAX) begin
			sig_sel = 8'hFF;
		end else if (acc_q < dls_pkg::ACC_MIN) begin
			sig_sel = 8'h00;
		end else begin
			sig_sel = {~acc_q[27], acc_q[26:20]};
		end
	end

	// Result register; the controller never finishes a neuron while it is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s3) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s3) begin
			out_index_q <= dls_pkg::OIDX_W'(k_s3);
			out_act_q   <= sig_rom[sig_sel];
			out_last_q  <= lastn_s3;
		end
	end

	assign res_valid      = out_valid_q;
	assign res_out_index  = out_index_q;
	assign res_activation = out_act_q;
	assign res_last       = out_last_q;

	assign status.empty = !tag_s1.valid && !tag_s2.valid && !done_s3 && !out_valid_q;

endmodule

FILE: rtl/core/dense_layer_sigmoid.sv
// Top level of the dense layer engine: controller plus datapath.
// Depends on dls_pkg, dls_if, dls_ctrl and dls_datapath.
//
//   channel  dir  handshake        payload
//   cmd      in   valid/ready      op, index, value
//   result   out  valid/ready      out_index, activation, last
//   cfg      in   cfg_we           cfg_index, cfg_data
//
// Load items are taken while the engine is idle. Within a neuron a run issues
// one multiply-accumulate per cycle through the single weight memory read port;
// between output neurons it waits for pipeline drain and result handoff.
// Reset clears control state only; the stores hold nothing defined until written.
// A stalled result holds the next neuron back; items are taken again once the
// last neuron's terms are issued.
module dense_layer_sigmoid (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [dls_pkg::CFG_IW-1:0] cfg_index,
	input  logic [dls_pkg::SIZE_W-1:0] cfg_data,
	dls_cmd_if.sink                    cmd,
	dls_res_if.source                  result
);

	dls_pkg::status_t status;
	dls_pkg::wr_t     wr;
	dls_pkg::issue_t  issue;

	dls_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.cmd_op    (cmd.op),
		.cmd_index (cmd.index),
		.cmd_value (cmd.value),
		.status    (status),
		.wr        (wr),
		.issue     (issue)
	);

	dls_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr             (wr),
		.issue          (issue),
		.status         (status),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.res_out_index  (result.out_index),
		.res_activation (result.activation),
		.res_last       (result.last)
	);

endmodule

FILE: rtl/core/dls_checker.sv
// Port-level checks of the dense layer engine, attached by bind.
// Depends on dls_pkg and the top level dense_layer_sigmoid.
module dls_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic [1:0]                 cmd_op,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [dls_pkg::OIDX_W-1:0] res_out_index,
	input logic [dls_pkg::ACT_W-1:0]  res_activation,
	input logic                       res_last
);

	logic [1:0]                 runs_q;
	logic [dls_pkg::OIDX_W-1:0] exp_idx_q;
	logic                       run_acc, res_acc;

	assign run_acc = cmd_valid && cmd_ready && (cmd_op == 2'(dls_pkg::OP_RUN));
	assign res_acc = res_valid && res_ready;

	// Runs whose results are not all delivered, and the next expected neuron.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_q    <= '0;
			exp_idx_q <= '0;
		end else begin
			runs_q <= runs_q + {1'b0, run_acc} - {1'b0, res_acc && res_last};
			if (res_acc) exp_idx_q <= res_last ? '0 : exp_idx_q + dls_pkg::OIDX_W'(1);
		end
	end

	// A stalled item stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_out_index)
		&& $stable(res_activation) && $stable(res_last))
		else $error("result item changed while stalled");

	// Results appear only for a run that was taken.
	a_res_owned: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> runs_q != 2'd0)
		else $error("result item without a pending run");

	// Neurons come out in index order, starting from zero.
	a_res_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> res_out_index == exp_idx_q)
		else $error("result item out of order");

endmodule

bind dense_layer_sigmoid dls_checker u_dls_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_op         (cmd.op),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_out_index  (result.out_index),
	.res_activation (result.activation),
	.res_last       (result.last)
);

FILE: tb/tb_dense_layer_sigmoid.sv
// Self-checking testbench for the dense layer engine with sigmoid activation.
// It depends on dls_pkg and the dls_cmd_if/dls_res_if interfaces. An in-bench
// predictor checks every result in order, with random idling on both channels.
module tb_dense_layer_sigmoid;
	import dls_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int DRAIN_CYCLES   = 16;
	localparam int TIMEOUT_CYCLES = 3000000;
	localparam int MAX_REPORTS    = 40;

	// Accumulator clamp in Q8.24 and the sigmoid table step e^(-1/32) in Q0.32.
	localparam longint ACC_HI   = 64'sd134217727;
	localparam longint ACC_LO   = -64'sd134217728;
	localparam longint unsigned EXP_Q32 = 64'd4162825044;

	typedef struct {
		logic [OIDX_W-1:0] neuron;
		logic [ACT_W-1:0]  act;
		logic              last_flag;
	} neuron_out_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [SIZE_W-1:0]   cfg_data;

	dls_cmd_if cmd_ch();
	dls_res_if res_ch();

	dense_layer_sigmoid u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.result    (res_ch)
	);

	// Mirror of the layer: stores, shape registers and the sigmoid table.
	logic [VAL_W-1:0]  weight_mem [W_DEPTH];
	logic [VAL_W-1:0]  bias_mem [V_DEPTH];
	logic [VAL_W-1:0]  data_mem [V_DEPTH];
	logic [SIZE_W-1:0] rows_reg;
	logic [SIZE_W-1:0] cols_reg;
	logic              dir_up_reg;
	logic [ACT_W-1:0]  sig_lut [256];

	neuron_out_t expected_neurons [$];
	int          error_count;
	int          send_idle_pct;
	int          stall_pct;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_REPORTS) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	// Rounded Q0.32 product; both operands stay below 2^32, so nothing overflows.
	function automatic longint unsigned q32_round_mul(input longint unsigned a,
			input longint unsigned b);
		return (a * b + 64'h8000_0000) >> 32;
	endfunction

	// Upper half holds round(1 / (1 + e^-x)) at cell centers, lower half mirrors it.
	function automatic void build_sigmoid_lut();
		longint unsigned pw;
		longint unsigned den;
		longint unsigned s;
		pw = EXP_Q32;
		for (int m = 0; m < 128; m++) begin
			den = 64'h1_0000_0000 + pw;
			s = ((64'd1 << 48) + (den >> 1)) / den;
			sig_lut[128 + m] = (s > 65535) ? 16'hFFFF : s[15:0];
			sig_lut[127 - m] = 16'(64'd65536 - s);
			pw = q32_round_mul(q32_round_mul(pw, EXP_Q32), EXP_Q32);
		end
	endfunction

	function automatic logic [ACT_W-1:0] sigmoid_of(input longint acc);
		longint c;
		c = acc;
		if (c > ACC_HI) c = ACC_HI;
		if (c < ACC_LO) c = ACC_LO;
		return sig_lut[int'((c - ACC_LO) >>> 20)];
	endfunction

	// A size of zero counts as one; sizes above the array clamp to the array.
	function automatic int eff_size(input logic [SIZE_W-1:0] v, input int cap);
		if (v == 0) return 1;
		if (v > cap) return cap;
		return int'(v);
	endfunction

	function automatic longint sext(input logic [VAL_W-1:0] v);
		return longint'($signed(v));
	endfunction

	// Update the mirror for one accepted item and queue the neurons a run produces.
	task automatic apply_to_model(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		int     n;
		int     m;
		int     outs;
		longint acc;
		case (op)
			OP_WEIGHT: begin
				if (idx < W_DEPTH) weight_mem[idx] = val;
			end
			OP_BIAS: begin
				if (idx < V_DEPTH) bias_mem[idx] = val;
			end
			OP_DATA: begin
				if (idx < V_DEPTH) data_mem[idx] = val;
			end
			default: begin
				n = eff_size(rows_reg, MAX_ROWS);
				m = eff_size(cols_reg, MAX_COLS);
				outs = dir_up_reg ? n : m;
				for (int k = 0; k < outs; k++) begin
					acc = sext(bias_mem[k]) * 4096;
					if (dir_up_reg) begin
						for (int t = 0; t < m; t++)
							acc += sext(weight_mem[k * m + t]) * sext(data_mem[t]);
					end else begin
						for (int t = 0; t < n; t++)
							acc += sext(weight_mem[t * m + k]) * sext(data_mem[t]);
					end
					expected_neurons.push_back('{neuron: OIDX_W'(k), act: sigmoid_of(acc),
						last_flag: (k == outs - 1)});
				end
			end
		endcase
	endtask

	// Send one item, idling first at random; valid stays high for a following item.
	task automatic send_item(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op    <= op;
		cmd_ch.index <= idx;
		cmd_ch.value <= val;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		apply_to_model(op, idx, val);
	endtask

	// Drop valid, then wait until every result is back.
	task automatic pause_until_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_neurons.size() != 0);
	endtask

	// Shape registers change only with the layer idle; the unused index is written too.
	task automatic set_layer_shape(input logic [SIZE_W-1:0] rows,
			input logic [SIZE_W-1:0] cols, input logic up);
		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_index <= CFG_DIR;
		cfg_data  <= {6'($urandom), up};
		@(posedge clk);
		cfg_index <= CFG_NONE;
		cfg_data  <= SIZE_W'($urandom);
		@(posedge clk);
		cfg_we     <= 1'b0;
		rows_reg   = rows;
		cols_reg   = cols;
		dir_up_reg = up;
	endtask

	// Mix of extremes, small values that land mid-table, and full-range values.
	function automatic logic [VAL_W-1:0] pick_value();
		int          pick;
		logic [31:0] r;
		pick = $urandom_range(99);
		r = $urandom;
		if (pick < 15) begin
			case (r[1:0])
				2'd0: return 16'h7FFF;
				2'd1: return 16'h8000;
				2'd2: return 16'h0000;
				default: return 16'hFFFF;
			endcase
		end
		if (pick < 60) return {{7{r[8]}}, r[8:0]};
		return r[15:0];
	endfunction

	// Results are taken at random; each one is compared with the oldest expectation.
	always @(posedge clk) begin
		res_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		neuron_out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_neurons.size() == 0) begin
				report_mismatch($sformatf("unexpected result, index %0d", res_ch.out_index));
			end else begin
				want = expected_neurons.pop_front();
				if (res_ch.out_index !== want.neuron)
					report_mismatch($sformatf("out_index %0d, expected %0d",
						res_ch.out_index, want.neuron));
				if (res_ch.activation !== want.act)
					report_mismatch($sformatf("activation %0d, expected %0d (index %0d)",
						res_ch.activation, want.act, want.neuron));
				if (res_ch.last !== want.last_flag)
					report_mismatch($sformatf("last %0b, expected %0b (index %0d)",
						res_ch.last, want.last_flag, want.neuron));
			end
		end
	end

	// Every store entry that a later run reads gets a value first: the first 64
	// weights, the whole data vector and the first eight biases.
	task automatic test_preload();
		for (int i = 0; i < 64; i++) send_item(OP_WEIGHT, IDX_W'(i), pick_value());
		for (int i = 0; i < 8; i++) send_item(OP_BIAS, IDX_W'(i), pick_value());
		for (int i = 0; i < V_DEPTH; i++) send_item(OP_DATA, IDX_W'(i), pick_value());
	endtask

	// Both clamp ends of the accumulator, and an accumulator of exactly zero.
	task automatic test_saturation();
		set_layer_shape(7'd2, 7'd2, 1'b1);
		send_item(OP_BIAS, 12'd0, 16'h7FFF);
		send_item(OP_BIAS, 12'd1, 16'h8000);
		send_item(OP_DATA, 12'd0, 16'h7FFF);
		send_item(OP_DATA, 12'd1, 16'h8000);
		send_item(OP_WEIGHT, 12'd0, 16'h7FFF);
		send_item(OP_WEIGHT, 12'd1, 16'h8000);
		send_item(OP_WEIGHT, 12'd2, 16'h7FFF);
		send_item(OP_WEIGHT, 12'd3, 16'h7FFF);
		send_item(OP_RUN, 12'hFFF, 16'hFFFF);
		set_layer_shape(7'd2, 7'd2, 1'b0);
		send_item(OP_RUN, 12'd0, 16'd0);
		send_item(OP_BIAS, 12'd0, 16'h0000);
		send_item(OP_DATA, 12'd0, 16'h0000);
		send_item(OP_DATA, 12'd1, 16'h0000);
		send_item(OP_RUN, 12'd0, 16'd0);
	endtask

	// Zero sizes count as one and sizes above the array count as the array size.
	task automatic test_size_limits();
		set_layer_shape(7'd0, 7'd127, 1'b1);
		send_item(OP_RUN, 12'd0, 16'd0);
		set_layer_shape(7'd127, 7'd0, 1'b0);
		send_item(OP_RUN, 12'd0, 16'd0);
		set_layer_shape(7'd1, 7'd1, 1'b1);
		send_item(OP_RUN, 12'd0, 16'd0);
	endtask

	// Bias and data writes past the vector depth must leave the stores alone.
	task automatic test_ignored_writes();
		set_layer_shape(7'd3, 7'd3, 1'b1);
		send_item(OP_BIAS, 12'd64, 16'h7FFF);
		send_item(OP_DATA, 12'hFFF, 16'h8000);
		send_item(OP_BIAS, 12'hFC0, 16'h8000);
		send_item(OP_WEIGHT, 12'hFFF, 16'h1234);
		send_item(OP_RUN, 12'd0, 16'd0);
	endtask

	// One shape, then mostly loads into the entries that shape reads, some noise, runs.
	// Shapes stay within the preloaded entries: small ones, or one row clamped wide.
	task automatic run_random_batch(input int n_items);
		int n;
		int m;
		int outs;
		int inner;
		int pick;
		if ($urandom_range(99) < 75)
			set_layer_shape(SIZE_W'($urandom_range(8)), SIZE_W'($urandom_range(8)),
				1'($urandom));
		else
			set_layer_shape(7'd0, SIZE_W'($urandom_range(127, 64)), 1'b1);
		n = eff_size(rows_reg, MAX_ROWS);
		m = eff_size(cols_reg, MAX_COLS);
		outs = dir_up_reg ? n : m;
		inner = dir_up_reg ? m : n;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				send_item(OP_RUN, IDX_W'($urandom), VAL_W'($urandom));
			end else if (pick < 75) begin
				case ($urandom_range(2))
					0: send_item(OP_WEIGHT,
						IDX_W'($urandom_range(n - 1) * m + $urandom_range(m - 1)),
						pick_value());
					1: send_item(OP_BIAS, IDX_W'($urandom_range(outs - 1)), pick_value());
					default: send_item(OP_DATA, IDX_W'($urandom_range(inner - 1)),
						pick_value());
				endcase
			end else begin
				send_item(op_t'($urandom_range(2)), IDX_W'($urandom), pick_value());
			end
			if ($urandom_range(99) < 4) pause_until_drained();
		end
		send_item(OP_RUN, IDX_W'($urandom), VAL_W'($urandom));
	endtask

	// Idling phases: none, sender mostly idle, receiver mostly stalled, both lightly.
	task automatic test_random_phases();
		int idle_mix [4]  = '{0, 75, 0, 10};
		int stall_mix [4] = '{0, 0, 75, 10};
		for (int p = 0; p < 4; p++) begin
			pause_until_drained();
			send_idle_pct = idle_mix[p];
			stall_pct     = stall_mix[p];
			for (int b = 0; b < 2; b++) run_random_batch(7);
		end
		send_idle_pct = 0;
		stall_pct     = 0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_NONE;
		cfg_data      = '0;
		cmd_ch.valid  = 1'b0;
		cmd_ch.op     = OP_WEIGHT;
		cmd_ch.index  = '0;
		cmd_ch.value  = '0;
		res_ch.ready  = 1'b0;
		error_count   = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		rows_reg      = 7'd64;
		cols_reg      = 7'd64;
		dir_up_reg    = 1'b1;
		build_sigmoid_lut();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_preload();
		test_saturation();
		test_size_limits();
		test_ignored_writes();
		test_random_phases();

		// Let the last run drain, then watch for stray results.
		pause_until_drained();
		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/dls_pkg.sv
rtl/core/dls_if.sv
rtl/core/dls_ctrl.sv
rtl/core/dls_datapath.sv
rtl/core/dense_layer_sigmoid.sv
rtl/core/dls_checker.sv
tb/tb_dense_layer_sigmoid.sv
